FILE: hw/rtl/red_pkg.sv
// Shared types and constants for the rotary encoder debounce and speed block.
package red_pkg;

	// Default width of the millisecond time base.
	localparam int TimeWidthDef = 32;

	// Divisor width of the shared divider: wide enough for detent count and rpm divisor.
	localparam int DivisorWidth = 24;

	// Numerator of the rpm estimate and the fallback period with no elapsed time.
	localparam logic [15:0] RpmNumer   = 16'd60000;
	localparam logic [15:0] MsPerIdle  = 16'd50;
	localparam logic [15:0] RpmSat     = 16'hFFFF;

	// Register reset values.
	localparam logic [15:0] DebounceRst  = 16'd250;
	localparam logic [15:0] TicksMsRst   = 16'd1000;
	localparam logic [7:0]  PeriodRst    = 8'd15;
	localparam logic [7:0]  DetentsRst   = 8'd24;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_DEBOUNCE_TICKS   = 3'd0,
		REG_TICKS_PER_MS     = 3'd1,
		REG_REPORT_PERIOD_MS = 3'd2,
		REG_DETENTS_PER_REV  = 3'd3,
		REG_ACTIVE_HIGH      = 3'd4
	} reg_idx_t;

	// Configuration register set.
	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [15:0] ticks_per_ms;
		logic [7:0]  report_period_ms;
		logic [7:0]  detents_per_rev;
		logic        active_high;
	} cfg_t;

	// Report request from the tick logic to the sequencer.
	typedef struct packed {
		logic               fire;
		logic               turned;
		logic signed [15:0] delta;
		logic               clicked;
		logic [15:0]        count;
		logic               elapsed_zero;
	} rep_t;

endpackage

FILE: hw/rtl/red_div.sv
// Shared restoring divider, one quotient bit per cycle.
module red_div #(
	parameter int TIME_WIDTH = red_pkg::TimeWidthDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [TIME_WIDTH-1:0]             dividend,
	input  logic [red_pkg::DivisorWidth-1:0]  divisor,
	output logic                              done,
	output logic [TIME_WIDTH-1:0]             quotient
);
	import red_pkg::*;

	localparam int CntW = $clog2(TIME_WIDTH + 1);

	logic                    busy_q;
	logic                    done_q;
	logic [CntW-1:0]         cnt_q;
	logic [TIME_WIDTH-1:0]   dvd_q;
	logic [DivisorWidth-1:0] dvs_q;
	logic [DivisorWidth-1:0] rem_q;
	logic [DivisorWidth:0]   rem_sh;
	logic [DivisorWidth:0]   rem_diff;
	logic                    ge;

	// One trial subtraction per cycle.
	assign rem_sh   = {rem_q, dvd_q[TIME_WIDTH-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(TIME_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register collects quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_diff[DivisorWidth-1:0] : rem_sh[DivisorWidth-1:0];
			dvd_q <= {dvd_q[TIME_WIDTH-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: hw/rtl/red_tick.sv
// Per-tick debounce, detent counting, time keeping and report check.
module red_tick #(
	parameter int TIME_WIDTH = red_pkg::TimeWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  a_level,
	input  logic                  b_level,
	input  logic                  button_level,
	input  red_pkg::cfg_t         cfg,
	output red_pkg::rep_t         rep,
	output logic [TIME_WIDTH-1:0] elapsed
);
	import red_pkg::*;

	logic                  prev_a_q, prev_btn_q;
	logic                  a_pend_q, btn_pend_q;
	logic [15:0]           a_timer_q, btn_timer_q;
	logic                  dir_q, click_q;
	logic signed [15:0]    delta_q;
	logic [15:0]           trig_q, sub_q;
	logic [TIME_WIDTH-1:0] now_q, last_q;
	logic [7:0]            per_q;

	logic                  a_pend_n, btn_pend_n, dir_n, click_n;
	logic [15:0]           a_timer_n, btn_timer_n, trig_n, sub_n;
	logic signed [15:0]    delta_n;
	logic [TIME_WIDTH-1:0] now_n, last_n, elapsed_n;
	logic [7:0]            per_n;
	logic                  a_active, btn_active;
	logic [15:0]           db_ticks, tpm;
	logic [7:0]            rpt;
	rep_t                  rep_n;

	// Next state of one sample tick.
	always_comb begin
		a_active   = a_level == cfg.active_high;
		btn_active = button_level == cfg.active_high;
		db_ticks   = (cfg.debounce_ticks == '0) ? 16'd1 : cfg.debounce_ticks;
		tpm        = (cfg.ticks_per_ms == '0) ? 16'd1 : cfg.ticks_per_ms;
		rpt        = (cfg.report_period_ms == '0) ? 8'd1 : cfg.report_period_ms;

		a_pend_n    = a_pend_q;
		a_timer_n   = a_timer_q;
		dir_n       = dir_q;
		btn_pend_n  = btn_pend_q;
		btn_timer_n = btn_timer_q;
		click_n     = click_q;
		trig_n      = trig_q;
		delta_n     = delta_q;
		sub_n       = sub_q + 16'd1;
		now_n       = now_q;
		last_n      = last_q;
		per_n       = per_q;
		elapsed_n   = '0;
		rep_n       = '0;

		// Debounce expiry on channel A counts a detent if A is still active.
		if (a_pend_q) begin
			if (a_timer_q != '0)
				a_timer_n = a_timer_q - 16'd1;
			if (a_timer_n == '0) begin
				a_pend_n = 1'b0;
				if (a_active) begin
					if (trig_q != 16'hFFFF)
						trig_n = trig_q + 16'd1;
					if (dir_q) begin
						if (delta_q != 16'sh7FFF)
							delta_n = delta_q + 16'sd1;
					end else begin
						if (delta_q != -16'sh8000)
							delta_n = delta_q - 16'sd1;
					end
				end
			end
		end

		// Debounce expiry on the button.
		if (btn_pend_q) begin
			if (btn_timer_q != '0)
				btn_timer_n = btn_timer_q - 16'd1;
			if (btn_timer_n == '0) begin
				btn_pend_n = 1'b0;
				if (btn_active)
					click_n = 1'b1;
			end
		end

		// Active edges start a debounce only when none was pending.
		if (!a_pend_q && prev_a_q != cfg.active_high && a_active) begin
			a_pend_n  = 1'b1;
			a_timer_n = db_ticks;
			dir_n     = !b_level;
		end
		if (!btn_pend_q && prev_btn_q != cfg.active_high && btn_active) begin
			btn_pend_n  = 1'b1;
			btn_timer_n = db_ticks;
		end

		// Millisecond and report period counting.
		if (sub_n >= tpm) begin
			sub_n = '0;
			now_n = now_q + TIME_WIDTH'(1);
			per_n = per_q + 8'd1;
			if (per_n >= rpt) begin
				per_n = '0;
				if (trig_n != '0 || click_n) begin
					rep_n.fire    = 1'b1;
					rep_n.clicked = click_n;
					click_n       = 1'b0;
					if (trig_n != '0) begin
						elapsed_n          = now_n - last_q;
						rep_n.turned       = 1'b1;
						rep_n.delta        = delta_n;
						rep_n.count        = trig_n;
						rep_n.elapsed_zero = elapsed_n == '0;
						last_n             = now_n;
						trig_n             = '0;
						delta_n            = '0;
					end
				end
			end
		end
	end

	// State registers advance once per accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q    <= 1'b1;
			prev_btn_q  <= 1'b1;
			a_pend_q    <= 1'b0;
			a_timer_q   <= '0;
			dir_q       <= 1'b0;
			btn_pend_q  <= 1'b0;
			btn_timer_q <= '0;
			click_q     <= 1'b0;
			delta_q     <= '0;
			trig_q      <= '0;
			sub_q       <= '0;
			now_q       <= '0;
			last_q      <= '0;
			per_q       <= '0;
		end else if (step) begin
			prev_a_q    <= a_level;
			prev_btn_q  <= button_level;
			a_pend_q    <= a_pend_n;
			a_timer_q   <= a_timer_n;
			dir_q       <= dir_n;
			btn_pend_q  <= btn_pend_n;
			btn_timer_q <= btn_timer_n;
			click_q     <= click_n;
			delta_q     <= delta_n;
			trig_q      <= trig_n;
			sub_q       <= sub_n;
			now_q       <= now_n;
			last_q      <= last_n;
			per_q       <= per_n;
		end
	end

	assign rep     = rep_n;
	assign elapsed = elapsed_n;

endmodule

FILE: hw/rtl/rotary_encoder_debounce_speed_top.sv
// Top level of the rotary encoder debounce and speed block.
//
//   channel  direction  transfer on          payload
//   s_*      in         s_tvalid & s_tready  tdata: a_level, b_level, button_level
//   m_*      out        m_tvalid & m_tready  tdata: turned, turn_delta, speed_rpm, clicked
//   cfg_*    in         cfg_we               cfg_addr selects register, cfg_data value
//
// A sample without a report leaves the sequencer idle; the next one is taken in the
// following cycle. A report with detents runs the shared bit-serial divider up to twice
// (ms per detent, then rpm); a click-only report goes straight to the output state.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register while new samples are taken, and the sequencer holds before loading it.
// Reset clears control state and loads register defaults; no clearing pass is needed.
module rotary_encoder_debounce_speed_top #(
	parameter int TIME_WIDTH = red_pkg::TimeWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] a_level, [1] b_level, [2] button_level, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] turned, [16:1] turn_delta, [32:17] speed_rpm,
	                               // [33] clicked, rest zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data
);
	import red_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_DIV_MS  = 5'b00010,
		ST_MUL     = 5'b00100,
		ST_DIV_RPM = 5'b01000,
		ST_OUT     = 5'b10000
	} state_t;

	state_t                  state_q;
	cfg_t                    cfg_q;
	rep_t                    rep;
	logic [TIME_WIDTH-1:0]   elapsed;
	logic                    s_accept;
	logic                    div_start, div_done;
	logic [TIME_WIDTH-1:0]   div_dividend, div_quo;
	logic [DivisorWidth-1:0] div_divisor;
	logic [15:0]             ms_q;
	logic                    res_turned_q, res_clicked_q;
	logic signed [15:0]      res_delta_q;
	logic [15:0]             res_rpm_q;
	logic                    m_tvalid_q;
	logic [39:0]             m_tdata_q;
	logic                    out_free;

	assign s_tready = state_q == ST_IDLE;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= DebounceRst;
			cfg_q.ticks_per_ms     <= TicksMsRst;
			cfg_q.report_period_ms <= PeriodRst;
			cfg_q.detents_per_rev  <= DetentsRst;
			cfg_q.active_high      <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= cfg_data;
				REG_TICKS_PER_MS:     cfg_q.ticks_per_ms     <= cfg_data;
				REG_REPORT_PERIOD_MS: cfg_q.report_period_ms <= cfg_data[7:0];
				REG_DETENTS_PER_REV:  cfg_q.detents_per_rev  <= cfg_data[7:0];
				REG_ACTIVE_HIGH:      cfg_q.active_high      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	red_tick #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_tick (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (s_accept),
		.a_level      (s_tdata[0]),
		.b_level      (s_tdata[1]),
		.button_level (s_tdata[2]),
		.cfg          (cfg_q),
		.rep          (rep),
		.elapsed      (elapsed)
	);

	// Divider operands: elapsed ms over detents, then the rpm numerator over ms * detents.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = elapsed;
		div_divisor  = DivisorWidth'(rep.count);
		if (state_q == ST_IDLE) begin
			div_start = s_accept && rep.fire && rep.turned && !rep.elapsed_zero;
		end else begin
			div_start    = state_q == ST_MUL;
			div_dividend = TIME_WIDTH'(RpmNumer);
			div_divisor  = DivisorWidth'(ms_q) * DivisorWidth'(cfg_q.detents_per_rev);
		end
	end

	red_div #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Report sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && rep.fire) begin
						if (!rep.turned)
							state_q <= ST_OUT;
						else if (rep.elapsed_zero)
							state_q <= ST_MUL;
						else
							state_q <= ST_DIV_MS;
					end
				end
				ST_DIV_MS: begin
					if (div_done) begin
						if (div_quo == '0 || cfg_q.detents_per_rev == '0 ||
						    div_quo > TIME_WIDTH'(RpmNumer))
							state_q <= ST_OUT;
						else
							state_q <= ST_MUL;
					end
				end
				ST_MUL:     state_q <= ST_DIV_RPM;
				ST_DIV_RPM: if (div_done) state_q <= ST_OUT;
				ST_OUT:     if (out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// Result fields gathered while the report is worked out.
	always_ff @(posedge clk) begin
		if (s_accept && rep.fire) begin
			res_turned_q  <= rep.turned;
			res_delta_q   <= rep.delta;
			res_clicked_q <= rep.clicked;
			res_rpm_q     <= '0;
			ms_q          <= MsPerIdle;
		end
		if (state_q == ST_DIV_MS && div_done) begin
			ms_q <= div_quo[15:0];
			if (div_quo == '0 || cfg_q.detents_per_rev == '0)
				res_rpm_q <= RpmSat;
			else
				res_rpm_q <= '0;
		end
		if (state_q == ST_DIV_RPM && div_done)
			res_rpm_q <= div_quo[15:0];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free)
			m_tdata_q <= {6'd0, res_clicked_q, res_rpm_q, res_delta_q, res_turned_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The divider only finishes while the sequencer waits for it.
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_MS || state_q == ST_DIV_RPM))
		else $error("divider finished outside a divide state");

	// A sample that triggers no report leaves the sequencer idle.
	a_no_fire_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !rep.fire) |=> state_q == ST_IDLE)
		else $error("sequencer left idle without a report");

	// A click-only result carries no delta and no speed, and has its click flag set.
	a_click_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tdata_q[0]) |-> (m_tdata_q[32:1] == '0 && m_tdata_q[33]))
		else $error("click-only result carries turn data");

	// A new result is loaded only when the previous one has been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> $stable(m_tdata_q))
		else $error("pending result overwritten");

endmodule

FILE: tb/sv/tb_rotary_encoder_debounce_speed_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rotary encoder debounce and speed block.
module tb_rotary_encoder_debounce_speed_top;
	import red_pkg::*;

	// Cycles to wait after the last report before a register write or the end.
	localparam int HoldOff    = 100;
	// Cycles without any transaction before the run is abandoned.
	localparam int StallLimit = 2000;
	localparam int MaxShown   = 10;

	localparam logic signed [15:0] DeltaMax = 16'sh7FFF;
	localparam logic signed [15:0] DeltaMin = 16'sh8000;

	// Directed ticks, one per entry: {button active, B level, A active}.
	localparam logic [2:0] DirectedTicks [20] = '{
		3'b000, 3'b001, 3'b001, 3'b001, 3'b100, 3'b111, 3'b111, 3'b010, 3'b011, 3'b010,
		3'b011, 3'b001, 3'b000, 3'b101, 3'b101, 3'b101, 3'b000, 3'b110, 3'b000, 3'b000
	};

	// One report as it leaves the block.
	typedef struct packed {
		logic               turned;
		logic signed [15:0] delta;
		logic [15:0]        rpm;
		logic               clicked;
	} report_t;

	// Tracks detents, clicks and the millisecond clock, and holds the reports still due.
	class detent_tracker;
		logic [15:0]        debounce, tick_div;
		logic [7:0]         period_ms, detents;
		logic               act_level;
		logic               prev_a, prev_btn, a_wait, btn_wait, dir_up, click;
		logic [15:0]        a_left, btn_left, count, sub_ms;
		logic signed [15:0] delta;
		logic [31:0]        now_ms, last_ms;
		logic [7:0]         period_cnt;
		report_t            pending_reports[$];
		int                 errors;

		function new();
			debounce   = DebounceRst;
			tick_div   = TicksMsRst;
			period_ms  = PeriodRst;
			detents    = DetentsRst;
			act_level  = 1'b0;
			prev_a     = 1'b1;
			prev_btn   = 1'b1;
			a_wait     = 1'b0;
			btn_wait   = 1'b0;
			dir_up     = 1'b0;
			click      = 1'b0;
			a_left     = '0;
			btn_left   = '0;
			count      = '0;
			sub_ms     = '0;
			delta      = '0;
			now_ms     = '0;
			last_ms    = '0;
			period_cnt = '0;
			errors     = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] value);
			case (idx)
				REG_DEBOUNCE_TICKS:   debounce = value;
				REG_TICKS_PER_MS:     tick_div = value;
				REG_REPORT_PERIOD_MS: period_ms = value[7:0];
				REG_DETENTS_PER_REV:  detents = value[7:0];
				REG_ACTIVE_HIGH:      act_level = value[0];
				default: ;
			endcase
		endfunction

		// Speed from the elapsed milliseconds and the detents counted in them.
		function logic [15:0] speed_of(logic [31:0] elapsed, logic [15:0] n);
			longint ms_per;
			if (elapsed == 0)
				ms_per = longint'(MsPerIdle);
			else
				ms_per = longint'(elapsed) / longint'((n == 0) ? 16'd1 : n);
			if (ms_per == 0 || detents == 0)
				return RpmSat;
			if (ms_per > longint'(RpmNumer))
				return 16'd0;
			return 16'(longint'(RpmNumer) / (ms_per * longint'(detents)));
		endfunction

		// Advances the state by one accepted sample and queues any report it causes.
		function void take_sample(logic a, logic b, logic btn);
			logic    a_on, btn_on, a_was, btn_was;
			report_t rep;
			a_on    = (a == act_level);
			btn_on  = (btn == act_level);
			a_was   = a_wait;
			btn_was = btn_wait;

			// Debounce windows that close on this tick.
			if (a_wait) begin
				if (a_left != 0)
					a_left--;
				if (a_left == 0) begin
					a_wait = 1'b0;
					if (a_on) begin
						if (count != 16'hFFFF)
							count++;
						if (dir_up) begin
							if (delta != DeltaMax)
								delta++;
						end else begin
							if (delta != DeltaMin)
								delta--;
						end
					end
				end
			end
			if (btn_wait) begin
				if (btn_left != 0)
					btn_left--;
				if (btn_left == 0) begin
					btn_wait = 1'b0;
					if (btn_on)
						click = 1'b1;
				end
			end

			// New edges open a window only on a channel that was idle.
			if (!a_was && prev_a != act_level && a_on) begin
				a_wait = 1'b1;
				a_left = (debounce == 0) ? 16'd1 : debounce;
				dir_up = !b;
			end
			if (!btn_was && prev_btn != act_level && btn_on) begin
				btn_wait = 1'b1;
				btn_left = (debounce == 0) ? 16'd1 : debounce;
			end
			prev_a   = a;
			prev_btn = btn;

			// Millisecond clock and the report check.
			sub_ms++;
			if (sub_ms < ((tick_div == 0) ? 16'd1 : tick_div))
				return;
			sub_ms = '0;
			now_ms++;
			period_cnt++;
			if (period_cnt < ((period_ms == 0) ? 8'd1 : period_ms))
				return;
			period_cnt = '0;
			if (count == 0 && !click)
				return;
			rep = '0;
			if (count != 0) begin
				rep.turned = 1'b1;
				rep.delta  = delta;
				rep.rpm    = speed_of(now_ms - last_ms, count);
				last_ms    = now_ms;
				count      = '0;
				delta      = '0;
			end
			rep.clicked = click;
			click       = 1'b0;
			pending_reports.push_back(rep);
		endfunction

		// Compares one report from the block with the oldest one due.
		function void check_report(logic [39:0] data);
			report_t got, want;
			got.turned  = data[0];
			got.delta   = data[16:1];
			got.rpm     = data[32:17];
			got.clicked = data[33];
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= MaxShown)
					$display("unexpected report: turned=%0d delta=%0d rpm=%0d clicked=%0d",
						got.turned, got.delta, got.rpm, got.clicked);
				return;
			end
			want = pending_reports.pop_front();
			if (got.turned != want.turned || got.delta != want.delta ||
					got.rpm != want.rpm || got.clicked != want.clicked) begin
				errors++;
				if (errors <= MaxShown)
					$display({"report mismatch: expected turned=%0d delta=%0d rpm=%0d ",
						"clicked=%0d, got turned=%0d delta=%0d rpm=%0d clicked=%0d"},
						want.turned, want.delta, want.rpm, want.clicked,
						got.turned, got.delta, got.rpm, got.clicked);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we   = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [15:0] cfg_data = '0;

	detent_tracker tracker;
	int unsigned   ticks_sent   = 0;
	int unsigned   quiet_cycles = 0;
	int unsigned   dbnc_now     = 32'(DebounceRst);
	int unsigned   btn_hold     = 0;
	logic          act_now      = 1'b0;
	bit            steady       = 1'b0;

	rotary_encoder_debounce_speed_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random back-pressure, checked at the rising edge.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_report(m_tdata);
	end

	// Watchdog on cycles with no transaction on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == StallLimit) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one sample and waits for its transaction.
	task automatic send_sample(logic a, logic b, logic btn);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, btn, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_sample(a, b, btn);
		ticks_sent++;
	endtask

	// Sends pin levels given as active or inactive under the current polarity.
	task automatic pins(logic a_on, logic b, logic btn_on);
		send_sample(a_on ? act_now : ~act_now, b, btn_on ? act_now : ~act_now);
	endtask

	task automatic hold(logic a_on, logic b, logic btn_on, int unsigned n);
		repeat (n) pins(a_on, b, btn_on);
	endtask

	// One clean detent with a debounce of one tick.
	task automatic detent(logic up);
		pins(1'b0, 1'b0, 1'b0);
		pins(1'b1, !up, 1'b0);
		pins(1'b1, !up, 1'b0);
	endtask

	// A tick with A as given and the button following its own random presses.
	task automatic rand_tick(logic a_on, logic b);
		logic btn_on;
		if (btn_hold == 0 && $urandom_range(0, 99) < 4)
			btn_hold = $urandom_range(1, dbnc_now + 3);
		btn_on = (btn_hold != 0);
		if (btn_hold != 0)
			btn_hold--;
		pins(a_on, b, btn_on);
	endtask

	// Stops the sample stream until every report has arrived and the block is quiet.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending_reports.size() != 0)
			@(negedge clk);
		repeat (HoldOff) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		tracker.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic configure(logic [15:0] dbnc, logic [15:0] tpm, logic [7:0] period,
			logic [7:0] det, logic act);
		settle();
		write_reg(REG_DEBOUNCE_TICKS, dbnc);
		write_reg(REG_TICKS_PER_MS, tpm);
		write_reg(REG_REPORT_PERIOD_MS, {8'h00, period});
		write_reg(REG_DETENTS_PER_REV, {8'h00, det});
		write_reg(REG_ACTIVE_HIGH, {15'h0000, act});
		cfg_we   <= 1'b0;
		act_now  = act;
		dbnc_now = (dbnc == 0) ? 32'd1 : 32'(dbnc);
	endtask

	task automatic play_directed();
		foreach (DirectedTicks[i])
			pins(DirectedTicks[i][0], DirectedTicks[i][1], DirectedTicks[i][2]);
	endtask

	// Mostly clean detents with random content, plus contact bounce and noise.
	task automatic random_run(int unsigned n);
		int unsigned stop_at, pick;
		logic        b_edge;
		stop_at  = ticks_sent + n;
		btn_hold = 0;
		while (ticks_sent < stop_at) begin
			pick   = $urandom_range(0, 99);
			b_edge = 1'($urandom_range(0, 1));
			if (pick < 65) begin
				// Clean detent: idle, then A held through its debounce window.
				repeat ($urandom_range(1, 2)) rand_tick(1'b0, 1'($urandom_range(0, 1)));
				rand_tick(1'b1, b_edge);
				repeat (dbnc_now + $urandom_range(0, 2))
					rand_tick(1'b1, 1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				// Contact bounce: A drops before the window closes, then may come back.
				rand_tick(1'b0, 1'($urandom_range(0, 1)));
				rand_tick(1'b1, b_edge);
				repeat ($urandom_range(0, dbnc_now - 1))
					rand_tick(1'b1, 1'($urandom_range(0, 1)));
				rand_tick(1'b0, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 1))
					rand_tick(1'b1, 1'($urandom_range(0, 1)));
			end else begin
				// Noise on both channels.
				repeat ($urandom_range(1, 4))
					rand_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks: both directions, a glitch, an edge inside the window,
		// a click alone and clicks with detents, first low active.
		configure(16'd2, 16'd1, 8'd4, 8'd24, 1'b0);
		play_directed();

		// Zero registers act as one; no detents per revolution saturates the speed.
		configure(16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
		play_directed();

		// Slow turning over a long report window with one detent per revolution.
		configure(16'd1, 16'd1, 8'd255, 8'd1, 1'b0);
		detent(1'b1);
		hold(1'b0, 1'b0, 1'b0, 120);
		detent(1'b0);
		hold(1'b0, 1'b0, 1'b0, 140);

		// Random part over several small settings, one of them without any idling.
		for (int seg = 0; seg < 5; seg++) begin
			configure(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
				8'($urandom_range(1, 8)), 8'($urandom_range(1, 255)),
				1'($urandom_range(0, 1)));
			steady = (seg == 2);
			random_run(200);
			steady = 1'b0;
		end

		settle();
		if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/red_pkg.sv
hw/rtl/red_div.sv
hw/rtl/red_tick.sv
hw/rtl/rotary_encoder_debounce_speed_top.sv
tb/sv/tb_rotary_encoder_debounce_speed_top.sv
